// File: rtl/bf5_pkg.sv
// Shared types, constants and the reciprocal table for the 5x5 box filter.
// Used by the top module, the column cell and the testbench; depends on nothing else.
package bf5_pkg;

	// Field and register widths
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned ACTION_W   = 1;
	localparam int unsigned COL_W      = 10;
	localparam int unsigned ROW_W      = 12;
	localparam int unsigned FW_W       = 11;
	localparam int unsigned FH_W       = 13;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned CFG_IDX_W  = 1;

	// Default frame limits and register reset values
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;
	localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Input word actions
	localparam logic [ACTION_W-1:0] ACT_PUSH  = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_DRAIN = 1'b1;

	// Window geometry: five taps per column, four older rows per line word
	localparam int unsigned TAPS     = 5;
	localparam int unsigned LANES    = TAPS - 1;
	localparam int unsigned LINE_W   = LANES * PIX_W;
	localparam int unsigned COLSUM_W = 11;
	localparam int unsigned SUM_W    = 13;
	localparam int unsigned CNT_W    = 5;

	// Division by the tap count as a multiply by a rounded-up reciprocal
	localparam int unsigned RECIP_SHIFT = 21;
	localparam int unsigned RECIP_W     = 22;
	localparam int unsigned PROD_W      = SUM_W + RECIP_W;

	// Result queue depth
	localparam int unsigned OUT_DEPTH = 8;

	typedef logic [TAPS-1:0][PIX_W-1:0] col_t;

	typedef struct packed {
		logic             shift;
		logic [TAPS-1:0]  row_ok;
		logic             col_ok;
	} cell_ctl_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} meta_t;

	typedef struct packed {
		logic [PIX_W-1:0] filtered;
		meta_t            meta;
	} res_t;

	// ceil(2^21 / n) for every possible tap count
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			5'd1:    r = 22'd2097152;
			5'd2:    r = 22'd1048576;
			5'd3:    r = 22'd699051;
			5'd4:    r = 22'd524288;
			5'd5:    r = 22'd419431;
			5'd6:    r = 22'd349526;
			5'd7:    r = 22'd299594;
			5'd8:    r = 22'd262144;
			5'd9:    r = 22'd233017;
			5'd10:   r = 22'd209716;
			5'd11:   r = 22'd190651;
			5'd12:   r = 22'd174763;
			5'd13:   r = 22'd161320;
			5'd14:   r = 22'd149797;
			5'd15:   r = 22'd139811;
			5'd16:   r = 22'd131072;
			5'd17:   r = 22'd123362;
			5'd18:   r = 22'd116509;
			5'd19:   r = 22'd110377;
			5'd20:   r = 22'd104858;
			5'd21:   r = 22'd99865;
			5'd22:   r = 22'd95326;
			5'd23:   r = 22'd91181;
			5'd24:   r = 22'd87382;
			5'd25:   r = 22'd83887;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/box_filter_5x5_gray.sv
// 5x5 box filter over a raster-order gray stream; one word per clock when out_ready holds.
// A result passes stages s1 to s5 and then the result queue after the word that completes its
// window; the window itself closes 2*width+2 counted words after the pixel (line RAM port plus cell chain).
// Throughput: one word per cycle, limited by the 8-entry result queue credit.
// Reset: asynchronous, active low; frame size returns to 640x480, counters to zero,
// line RAM contents stay undefined and are never read for in-frame taps before written.
module box_filter_5x5_gray #(
	parameter int unsigned MAX_WIDTH  = bf5_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = bf5_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [bf5_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bf5_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bf5_pkg::ACTION_W-1:0]    action,
	input  logic [bf5_pkg::PIX_W-1:0]       pixel,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bf5_pkg::PIX_W-1:0]       filtered,
	output logic [bf5_pkg::COL_W-1:0]       out_col,
	output logic [bf5_pkg::ROW_W-1:0]       out_row,
	output logic                            frame_last
);
	import bf5_pkg::*;

	localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HB    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CB    = $clog2(MAX_WIDTH);
	localparam int unsigned RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned LB    = $clog2(2 * MAX_WIDTH + 3);
	localparam int unsigned EWW   = (WW > FW_W) ? WW : FW_W;
	localparam int unsigned EHB   = (HB > FH_W) ? HB : FH_W;
	localparam int unsigned OCC_W = $clog2(OUT_DEPTH + 1);

	// Configuration and frame counters
	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [CB-1:0]    wcol_q;
	logic [RB-1:0]    in_row_q;
	logic [CB-1:0]    emit_col_q;
	logic [RB-1:0]    emit_row_q;
	logic [LB-1:0]    lead_q;
	logic             frame_done_q;
	logic [OCC_W-1:0] occ_q;

	logic [WW-1:0]    w_eff;
	logic [HB-1:0]    h_eff;
	logic [EWW-1:0]   fw_ext;
	logic [EHB-1:0]   fh_ext;
	logic [LB-1:0]    lag;
	logic             acc, wr_pix, counted, emit, last;
	logic             col_wrap, row_wrap, emit_col_wrap;
	logic [RB+1:0]    rp2;
	logic [CB+1:0]    cp2;
	logic [TAPS-1:0]  rok, cok;
	meta_t            meta;

	// Stage registers
	logic             cnt_s1, emit_s1, byp_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [CB-1:0]    wcol_s1;
	logic [TAPS-1:0]  rok_s1, cok_s1;
	meta_t            meta_s1;
	logic             emit_s2;
	logic [TAPS-1:0]  rok_s2, cok_s2;
	meta_t            meta_s2;
	logic             emit_s3;
	logic [CNT_W-1:0] cnt_s3;
	meta_t            meta_s3;
	logic             emit_s4;
	logic [SUM_W-1:0] sum_s4;
	logic [RECIP_W-1:0] recip_s4;
	meta_t            meta_s4;
	logic             emit_s5;
	logic [PROD_W-1:0] prod_s5;
	meta_t            meta_s5;

	logic [LINE_W-1:0] ram_rdata, old_word, new_word, fwd_q;
	col_t              col_new;
	col_t              col_q [TAPS];
	cell_ctl_t         cell_ctl [TAPS];
	logic [COLSUM_W-1:0] colsum_s3 [TAPS];
	logic [SUM_W-1:0]  sum_all;
	logic [2:0]        nr, nc;
	res_t              res_in, res_out;
	logic              q_nempty;

	// Effective frame size, clamped to 1..limit.
	always_comb begin
		fw_ext = EWW'(frame_width_q);
		fh_ext = EHB'(frame_height_q);
		if (fw_ext == '0) begin
			w_eff = WW'(1);
		end else if (fw_ext > EWW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_ext);
		end
		if (fh_ext == '0) begin
			h_eff = HB'(1);
		end else if (fh_ext > EHB'(MAX_HEIGHT)) begin
			h_eff = HB'(MAX_HEIGHT);
		end else begin
			h_eff = HB'(fh_ext);
		end
		lag = LB'({w_eff, 1'b0}) + LB'(2);
	end

	// Word classification at the input handshake.
	always_comb begin
		acc           = in_valid & in_ready;
		wr_pix        = acc & ~frame_done_q & (action == ACT_PUSH);
		counted       = acc & (frame_done_q | (action == ACT_PUSH));
		emit          = counted & ~(lead_q < lag);
		col_wrap      = (WW'(wcol_q) + WW'(1)) >= w_eff;
		row_wrap      = (HB'(in_row_q) + HB'(1)) >= h_eff;
		emit_col_wrap = (WW'(emit_col_q) + WW'(1)) >= w_eff;
		last          = emit & emit_col_wrap & ((HB'(emit_row_q) + HB'(1)) >= h_eff);
	end

	// Which taps of the window around the next result lie inside the frame.
	always_comb begin
		rp2 = (RB+2)'(emit_row_q) + (RB+2)'(2);
		cp2 = (CB+2)'(emit_col_q) + (CB+2)'(2);
		for (int i = 0; i < TAPS; i++) begin
			rok[i] = (rp2 >= (RB+2)'(i)) && (rp2 < ((RB+2)'(h_eff) + (RB+2)'(i)));
			cok[i] = (cp2 >= (CB+2)'(i)) && (cp2 < ((CB+2)'(w_eff) + (CB+2)'(i)));
		end
		meta.col  = COL_W'(emit_col_q);
		meta.row  = ROW_W'(emit_row_q);
		meta.last = emit_col_wrap & ((HB'(emit_row_q) + HB'(1)) >= h_eff);
	end

	// Configuration registers and frame sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
			wcol_q         <= '0;
			in_row_q       <= '0;
			emit_col_q     <= '0;
			emit_row_q     <= '0;
			lead_q         <= '0;
			frame_done_q   <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= FW_W'(cfg_wdata);
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
			wcol_q       <= '0;
			in_row_q     <= '0;
			emit_col_q   <= '0;
			emit_row_q   <= '0;
			lead_q       <= '0;
			frame_done_q <= 1'b0;
		end else if (last) begin
			wcol_q       <= '0;
			in_row_q     <= '0;
			emit_col_q   <= '0;
			emit_row_q   <= '0;
			lead_q       <= '0;
			frame_done_q <= 1'b0;
		end else begin
			if (counted) begin
				wcol_q <= col_wrap ? '0 : wcol_q + 1'b1;
			end
			if (wr_pix && col_wrap) begin
				if (row_wrap) begin
					in_row_q     <= '0;
					frame_done_q <= 1'b1;
				end else begin
					in_row_q <= in_row_q + 1'b1;
				end
			end
			if (counted && !emit) begin
				lead_q <= lead_q + 1'b1;
			end
			if (emit) begin
				if (emit_col_wrap) begin
					emit_col_q <= '0;
					emit_row_q <= emit_row_q + 1'b1;
				end else begin
					emit_col_q <= emit_col_q + 1'b1;
				end
			end
		end
	end

	// Result credit: results in flight plus results waiting in the queue.
	assign in_ready = (occ_q < OCC_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(acc & emit) - OCC_W'(out_valid & out_ready);
		end
	end

	// Line RAM: per column the four rows above the current one.
	bf5_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (cnt_s1),
		.waddr(wcol_s1),
		.wdata(new_word),
		.raddr(wcol_q),
		.rdata(ram_rdata)
	);

	// A word written last cycle to the same column is forwarded around the RAM.
	assign old_word = byp_s1 ? fwd_q : ram_rdata;
	assign new_word = {old_word[LINE_W-PIX_W-1:0], pix_s1};
	assign col_new  = col_t'({old_word, pix_s1});

	always_ff @(posedge clk) begin
		if (cnt_s1) begin
			fwd_q <= new_word;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1  <= 1'b0;
			emit_s1 <= 1'b0;
			byp_s1  <= 1'b0;
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
			emit_s4 <= 1'b0;
			emit_s5 <= 1'b0;
		end else begin
			cnt_s1  <= counted;
			emit_s1 <= emit;
			byp_s1  <= counted & cnt_s1 & (wcol_q == wcol_s1);
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
			emit_s4 <= emit_s3;
			emit_s5 <= emit_s4;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		pix_s1   <= pixel;
		wcol_s1  <= wcol_q;
		rok_s1   <= rok;
		cok_s1   <= cok;
		meta_s1  <= meta;
		rok_s2   <= rok_s1;
		cok_s2   <= cok_s1;
		meta_s2  <= meta_s1;
		cnt_s3   <= CNT_W'({3'b000, nr} * {3'b000, nc});
		meta_s3  <= meta_s2;
		sum_s4   <= sum_all;
		recip_s4 <= recip_of(cnt_s3);
		meta_s4  <= meta_s3;
		prod_s5  <= PROD_W'(sum_s4) * PROD_W'(recip_s4);
		meta_s5  <= meta_s4;
	end

	assign nr = 3'($countones(rok_s2));
	assign nc = 3'($countones(cok_s2));

	// Chain of column cells; cell j holds the column of the word j places back.
	for (genvar j = 0; j < TAPS; j++) begin : g_cell
		always_comb begin
			cell_ctl[j].shift  = cnt_s1;
			cell_ctl[j].row_ok = rok_s2;
			cell_ctl[j].col_ok = cok_s2[j];
		end
		if (j == 0) begin : g_head
			bf5_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl[j]),
				.col_in   (col_new),
				.col_out  (col_q[j]),
				.colsum_s3(colsum_s3[j])
			);
		end else begin : g_body
			bf5_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl[j]),
				.col_in   (col_q[j-1]),
				.col_out  (col_q[j]),
				.colsum_s3(colsum_s3[j])
			);
		end
	end

	// Window total from the five column sums.
	always_comb begin
		sum_all = '0;
		for (int j = 0; j < TAPS; j++) begin
			sum_all = sum_all + SUM_W'(colsum_s3[j]);
		end
	end

	// Result queue.
	always_comb begin
		res_in.filtered = prod_s5[RECIP_SHIFT +: PIX_W];
		res_in.meta     = meta_s5;
	end

	bf5_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (emit_s5),
		.wdata (res_in),
		.pop   (out_valid & out_ready),
		.nempty(q_nempty),
		.rdata (res_out)
	);

	assign out_valid  = q_nempty;
	assign filtered   = res_out.filtered;
	assign out_col    = res_out.meta.col;
	assign out_row    = res_out.meta.row;
	assign frame_last = res_out.meta.last;

	// Credit never exceeds the queue depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(OUT_DEPTH))
		else $error("result credit above queue depth");

	// A waiting result is always covered by credit.
	a_occ_cover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occ_q != '0))
		else $error("result waiting without credit");

	// The last result of a frame restarts the counters.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> ((lead_q == '0) && !frame_done_q && (emit_col_q == '0)))
		else $error("frame end did not restart counters");

	// Once all pixels are in, the input row counter has wrapped.
	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done_q |-> (in_row_q == '0))
		else $error("frame complete with row counter not wrapped");

endmodule

// File: rtl/bf5_ram.sv
// Generic simple dual-port RAM with a registered read port.
// Standalone; no package needed.
module bf5_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/bf5_cell.sv
// One window column cell: holds five pixels of one column and passes them on.
// Depends on bf5_pkg for the column and control types.
module bf5_cell (
	input  logic                          clk,
	input  bf5_pkg::cell_ctl_t            ctl,
	input  bf5_pkg::col_t                 col_in,
	output bf5_pkg::col_t                 col_out,
	output logic [bf5_pkg::COLSUM_W-1:0]  colsum_s3
);
	import bf5_pkg::*;

	col_t                col_q;
	logic [COLSUM_W-1:0] colsum;

	// The column moves one cell along for every counted word.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// Masked sum of the taps of this column that lie inside the frame.
	always_comb begin
		colsum = '0;
		for (int i = 0; i < TAPS; i++) begin
			if (ctl.row_ok[i]) begin
				colsum = colsum + COLSUM_W'(col_q[i]);
			end
		end
		if (!ctl.col_ok) begin
			colsum = '0;
		end
	end

	always_ff @(posedge clk) begin
		colsum_s3 <= colsum;
	end

endmodule

// File: rtl/bf5_fifo.sv
// Small register queue that holds finished results until they are taken.
// Standalone; widths come from its parameters.
module bf5_fifo #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             nempty,
	output logic [WIDTH-1:0] rdata
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (CW'(wr_ptr_q) == CW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (CW'(rd_ptr_q) == CW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign nempty = (count_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

endmodule

// File: sim/tb_box_filter_5x5_gray.sv
// Self-checking testbench for the 5x5 gray box filter: drives pixel and drain words,
// predicts every result in a local model of the filter and compares it field by field.
// Depends on bf5_pkg and rtl/box_filter_5x5_gray.sv.
`timescale 1ns / 100ps

module tb_box_filter_5x5_gray;
	import bf5_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int SETTLE = 24;

	typedef struct {
		logic [PIX_W-1:0] filtered;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} blur_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [ACTION_W-1:0]  action = ACT_PUSH;
	logic [PIX_W-1:0]     pixel = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIX_W-1:0]     filtered;
	logic [COL_W-1:0]     out_col;
	logic [ROW_W-1:0]     out_row;
	logic                 frame_last;

	box_filter_5x5_gray u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .pixel(pixel),
		.out_valid(out_valid), .out_ready(out_ready), .filtered(filtered),
		.out_col(out_col), .out_row(out_row), .frame_last(frame_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model state of the filter.
	logic [PIX_W-1:0] line_mem [0:1023][0:7];
	int unsigned m_width = 640, m_height = 480;
	int unsigned m_in_col, m_in_row, m_emit_col, m_emit_row, m_lead;
	bit m_done;

	blur_t pending_q[$];
	int errors = 0;
	int words_sent = 0;
	int cycles = 0;
	bit calm = 1'b0;

	function automatic int unsigned eff_width();
		return (m_width < 1) ? 1 : (m_width > 1024) ? 1024 : m_width;
	endfunction

	function automatic int unsigned eff_height();
		return (m_height < 1) ? 1 : (m_height > 4096) ? 4096 : m_height;
	endfunction

	function automatic void restart_model();
		m_in_col = 0; m_in_row = 0; m_emit_col = 0; m_emit_row = 0;
		m_lead = 0; m_done = 1'b0;
	endfunction

	// Mean of the in-frame part of the 5x5 neighborhood, floor division.
	function automatic logic [PIX_W-1:0] neighborhood_mean(int r, int c, int w, int h);
		int unsigned sum, hits;
		sum = 0; hits = 0;
		for (int dy = -2; dy <= 2; dy++)
			for (int dx = -2; dx <= 2; dx++)
				if (r + dy >= 0 && r + dy < h && c + dx >= 0 && c + dx < w) begin
					sum += line_mem[c + dx][(r + dy) % 8];
					hits++;
				end
		return PIX_W'(sum / hits);
	endfunction

	// Advance the model by one accepted word and queue the result it causes.
	function automatic void blur_step(logic [ACTION_W-1:0] act, logic [PIX_W-1:0] pix);
		int unsigned w, h;
		blur_t res;
		w = eff_width();
		h = eff_height();
		if (!m_done) begin
			if (act == ACT_DRAIN) return;
			line_mem[m_in_col][m_in_row % 8] = pix;
			m_in_col++;
			if (m_in_col >= w) begin
				m_in_col = 0;
				m_in_row++;
				if (m_in_row >= h) begin
					m_in_row = 0;
					m_done = 1'b1;
				end
			end
		end
		if (m_lead < 2 * w + 2) begin
			m_lead++;
			return;
		end
		res.filtered = neighborhood_mean(m_emit_row, m_emit_col, w, h);
		res.col = COL_W'(m_emit_col);
		res.row = ROW_W'(m_emit_row);
		res.last = (m_emit_row + 1 >= h) && (m_emit_col + 1 >= w);
		pending_q.push_back(res);
		if (res.last) restart_model();
		else begin
			m_emit_col++;
			if (m_emit_col >= w) begin
				m_emit_col = 0;
				m_emit_row++;
			end
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// Cycle limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stall per word, then check against the oldest expectation.
	int stall_left = 0;
	always @(posedge clk) begin
		blur_t want;
		int next_stall;
		next_stall = stall_left;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) report_mismatch("unexpected word", 1, 0);
			else begin
				want = pending_q.pop_front();
				if (filtered !== want.filtered)
					report_mismatch("filtered", filtered, want.filtered);
				if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
				if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
				if (frame_last !== want.last)
					report_mismatch("frame_last", frame_last, want.last);
			end
			next_stall = calm ? 0 : $urandom_range(0, 5);
		end else if (next_stall > 0)
			next_stall--;
		stall_left <= next_stall;
		out_ready <= arst_n && (next_stall == 0);
	end

	// Send one word: random gap, then hold valid until accepted.
	task automatic send_word(logic [ACTION_W-1:0] act, logic [PIX_W-1:0] pix);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pixel <= pix;
		do @(posedge clk); while (!(in_valid && in_ready));
		blur_step(act, pix);
		words_sent++;
	endtask

	// Drop valid, wait for every expected word, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_FRAME_WIDTH) m_width = val & 11'h7FF;
		else m_height = val;
		restart_model();
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
	endtask

	// One whole frame: pixels with optional ignored drains, then the flush words.
	task automatic run_frame(int noise_pct);
		int unsigned n;
		n = eff_width() * eff_height();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise_pct) send_word(ACT_DRAIN, PIX_W'($urandom));
			send_word(ACT_PUSH, PIX_W'($urandom));
		end
		n = 2 * eff_width() + 2;
		for (int i = 0; i < n; i++)
			send_word(($urandom_range(0, 3) == 0) ? ACT_PUSH : ACT_DRAIN, PIX_W'($urandom));
	endtask

	// Default 640x480 after reset: a partial frame that the next test restarts by writing the size.
	task automatic test_reset_size();
		for (int i = 0; i < 1300; i++) send_word(ACT_PUSH, PIX_W'($urandom));
		wait_idle();
	endtask

	// Short directed frame: extreme pixels, an early drain, pushes after the frame.
	task automatic test_directed();
		set_size(5, 4);
		send_word(ACT_DRAIN, 8'hFF);
		for (int i = 0; i < 20; i++) send_word(ACT_PUSH, (i % 3 == 0) ? 8'hFF : 8'h00);
		send_word(ACT_PUSH, 8'hAA);
		send_word(ACT_PUSH, 8'h55);
		for (int i = 0; i < 10; i++) send_word(ACT_DRAIN, 8'h00);
		wait_idle();
	endtask

	// Size extremes: zero acts as one, above the maximum clamps.
	task automatic test_size_limits();
		set_size(0, 0);
		run_frame(10);
		run_frame(0);
		wait_idle();
		// A clamped wide frame gives nothing before its long lead is filled.
		set_size(2047, 3);
		for (int i = 0; i < 100; i++) send_word(ACT_PUSH, PIX_W'($urandom));
		wait_idle();
		// A clamped tall frame keeps running past the row count's low bits.
		set_size(1, 4097);
		for (int i = 0; i < 100; i++) send_word(ACT_PUSH, PIX_W'($urandom));
		wait_idle();
	endtask

	// Random small frames, noise, restarts mid-frame and pauses between them.
	task automatic test_random_frames();
		int start, n;
		start = words_sent;
		while (words_sent - start < 400) begin
			set_size($urandom_range(1, 12), $urandom_range(1, 9));
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 40);
				for (int i = 0; i < n; i++)
					send_word(ACTION_W'($urandom), PIX_W'($urandom));
				wait_idle();
			end else begin
				run_frame(5);
				if ($urandom_range(0, 2) == 0) run_frame(0);
				if ($urandom_range(0, 5) == 0) wait_idle();
				for (int i = 0; i < 3; i++) send_word(ACT_DRAIN, PIX_W'($urandom));
			end
			calm = 1'b0;
			wait_idle();
		end
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		write_reg(REG_FRAME_WIDTH, 13'h1800);
		for (int i = 0; i < 50; i++) send_word(ACT_PUSH, PIX_W'($urandom));
		wait_idle();
	endtask

	initial begin
		for (int c = 0; c < 1024; c++)
			for (int l = 0; l < 8; l++) line_mem[c][l] = '0;
		restart_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_directed();
		test_size_limits();
		test_random_frames();
		wait_idle();
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
